// ===== rtl/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types, command codes and the step-count table for the I2C master
// bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_SACK  = 3'd4;
  localparam logic [2:0] CMD_RACK  = 3'd5;

  localparam logic [15:0] PHASE_RESET = 16'd720;
  localparam logic [7:0]  MSB_MASK    = 8'h80;

  typedef struct packed {
    logic       cmd_ok;
    logic [2:0] req_type;
    logic [7:0] tx_data;
    logic       sda_in;
  } i2cms_item_t;

  function automatic logic [4:0] seq_len(input logic [2:0] cmd);
    logic [4:0] len;
    unique case (cmd)
      CMD_START: len = 5'd4;
      CMD_STOP:  len = 5'd3;
      CMD_WRITE: len = 5'd24;
      CMD_READ:  len = 5'd25;
      CMD_SACK:  len = 5'd3;
      default:   len = 5'd4;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/i2cms_front.sv =====
// ----------------------------------------------------------------------------
// i2cms_front
// Input register: accepts one tick item per cycle while the queue is not
// full, classifies the command and selects the data latched with it.
// ----------------------------------------------------------------------------
module i2cms_front import i2cms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd_valid,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_tx_ack,
  input  logic        in_sda_in,
  output logic        fwd_valid,
  input  logic        fwd_full,
  output i2cms_item_t fwd_item
);

  logic        valid_r;
  logic        valid_nxt;
  i2cms_item_t item_r;
  i2cms_item_t item_nxt;
  logic        take;
  logic        moved;

  assign moved    = valid_r && !fwd_full;
  assign in_stall = valid_r && fwd_full;
  assign take     = in_valid && !in_stall;

  always_comb begin
    item_nxt.cmd_ok   = in_cmd_valid && (in_req_type <= CMD_RACK);
    item_nxt.req_type = in_req_type;
    item_nxt.tx_data  = (in_req_type == CMD_SACK) ? {7'd0, in_tx_ack} : in_tx_byte;
    item_nxt.sda_in   = in_sda_in;
  end

  always_comb begin
    priority if (take) begin
      valid_nxt = 1'b1;
    end else if (moved) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_nxt;
    end
  end

  assign fwd_valid = valid_r;
  assign fwd_item  = item_r;

endmodule

// ===== rtl/i2cms_queue.sv =====
// ----------------------------------------------------------------------------
// i2cms_queue
// Short in-order item queue between the front and the back.
// ----------------------------------------------------------------------------
module i2cms_queue import i2cms_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  i2cms_item_t push_item,
  output logic        full,
  input  logic        pop,
  output logic        nonempty,
  output i2cms_item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  i2cms_item_t   mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = (count_r == FULL_COUNT);
  assign nonempty = (count_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full && !do_pop |=> count_r == FULL_COUNT)
    else $error("queue lost its fill while full");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers differ while empty");

endmodule

// ===== rtl/i2cms_back.sv =====
// ----------------------------------------------------------------------------
// i2cms_back
// Pin sequencer: plays one tick per queued item and registers the result.
// ----------------------------------------------------------------------------
module i2cms_back import i2cms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        q_nonempty,
  input  i2cms_item_t q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_rx_byte,
  output logic        out_rx_ack
);

  logic [15:0] phase_r;
  logic        running_r, running_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [4:0]  step_r, step_nxt, step_inc;
  logic [15:0] timer_r, timer_nxt;
  logic [16:0] timer_inc;
  logic [1:0]  k_r, k_nxt;
  logic [2:0]  b_r, b_nxt;
  logic [7:0]  tx_r, tx_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        ack_r, ack_nxt;
  logic        busy_nxt, done_nxt;
  logic [15:0] limit;
  logic        out_valid_r, out_valid_nxt;
  logic        out_busy_r, out_done_r;

  assign limit = (phase_r == '0) ? 16'd1 : phase_r;
  assign q_pop = q_nonempty && (!out_valid_r || !out_stall);

  always_comb begin
    running_nxt = running_r;
    cmd_nxt     = cmd_r;
    step_nxt    = step_r;
    timer_nxt   = timer_r;
    k_nxt       = k_r;
    b_nxt       = b_r;
    tx_nxt      = tx_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    shift_nxt   = shift_r;
    ack_nxt     = ack_r;
    busy_nxt    = 1'b0;
    done_nxt    = 1'b0;
    timer_inc   = '0;
    step_inc    = '0;
    if (!running_r && q_item.cmd_ok) begin
      running_nxt = 1'b1;
      cmd_nxt     = q_item.req_type;
      step_nxt    = '0;
      timer_nxt   = '0;
      k_nxt       = '0;
      b_nxt       = '0;
      tx_nxt      = q_item.tx_data;
    end
    if (running_nxt) begin
      busy_nxt = 1'b1;
      if (timer_nxt == '0) begin
        unique case (cmd_nxt)
          CMD_START: begin
            priority case (step_nxt)
              5'd0:    sda_nxt = 1'b1;
              5'd1:    scl_nxt = 1'b1;
              5'd2:    sda_nxt = 1'b0;
              default: scl_nxt = 1'b0;
            endcase
          end
          CMD_STOP: begin
            priority case (step_nxt)
              5'd0:    sda_nxt = 1'b0;
              5'd1:    scl_nxt = 1'b1;
              default: sda_nxt = 1'b1;
            endcase
          end
          CMD_WRITE: begin
            priority case (k_nxt)
              2'd0:    sda_nxt = tx_nxt[3'd7 - b_nxt];
              2'd1:    scl_nxt = 1'b1;
              default: scl_nxt = 1'b0;
            endcase
          end
          CMD_READ: begin
            if (step_nxt == '0) begin
              sda_nxt   = 1'b1;
              shift_nxt = '0;
            end else begin
              priority case (k_nxt)
                2'd0:    scl_nxt = 1'b1;
                2'd1:    if (q_item.sda_in) shift_nxt[3'd7 - b_nxt] = 1'b1;
                default: scl_nxt = 1'b0;
              endcase
            end
          end
          CMD_SACK: begin
            priority case (step_nxt)
              5'd0:    sda_nxt = tx_nxt[0];
              5'd1:    scl_nxt = 1'b1;
              default: scl_nxt = 1'b0;
            endcase
          end
          default: begin
            priority case (step_nxt)
              5'd0:    sda_nxt = 1'b1;
              5'd1:    scl_nxt = 1'b1;
              5'd2:    ack_nxt = q_item.sda_in;
              default: scl_nxt = 1'b0;
            endcase
          end
        endcase
      end
      timer_inc = {1'b0, timer_nxt} + 17'd1;
      if (timer_inc >= {1'b0, limit}) begin
        timer_nxt = '0;
        step_inc  = step_nxt + 5'd1;
        if (!(cmd_nxt == CMD_READ && step_nxt == '0)) begin
          if (k_nxt == 2'd2) begin
            k_nxt = '0;
            b_nxt = b_nxt + 3'd1;
          end else begin
            k_nxt = k_nxt + 2'd1;
          end
        end
        if (step_inc >= seq_len(cmd_nxt)) begin
          running_nxt = 1'b0;
          step_nxt    = '0;
          done_nxt    = 1'b1;
        end else begin
          step_nxt = step_inc;
        end
      end else begin
        timer_nxt = timer_inc[15:0];
      end
    end
  end

  always_comb begin
    priority if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PHASE_RESET;
    end else if (cfg_wr_en) begin
      phase_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      cmd_r       <= CMD_START;
      step_r      <= '0;
      timer_r     <= '0;
      k_r         <= '0;
      b_r         <= '0;
      tx_r        <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      shift_r     <= '0;
      ack_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        running_r <= running_nxt;
        cmd_r     <= cmd_nxt;
        step_r    <= step_nxt;
        timer_r   <= timer_nxt;
        k_r       <= k_nxt;
        b_r       <= b_nxt;
        tx_r      <= tx_nxt;
        scl_r     <= scl_nxt;
        sda_r     <= sda_nxt;
        shift_r   <= shift_nxt;
        ack_r     <= ack_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_busy_r <= busy_nxt;
      out_done_r <= done_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_scl_out  = scl_r;
  assign out_sda_out  = sda_r;
  assign out_busy_res = out_busy_r;
  assign out_done_res = out_done_r;
  assign out_rx_byte  = shift_r;
  assign out_rx_ack   = ack_r;

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_busy_r)
    else $error("done without busy");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (timer_r == '0) && (step_r == '0))
    else $error("idle sequencer holds a step or timer");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (step_r < seq_len(cmd_r)) && (cmd_r <= CMD_RACK))
    else $error("step beyond command length");

endmodule

// ===== rtl/i2c_master_bit_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master pin sequencer: one item is one clock tick; each tick returns
// the SCL/SDA drive levels, busy/done and the received byte and ack.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_stall   cmd_valid req_type tx_byte
//                                              tx_ack sda_in
//   out_      output     out_valid / out_stall scl_out sda_out busy_res
//                                              done_res rx_byte rx_ack
//   cfg_      input      cfg_wr_en             cfg_wr_data (phase_ticks)
//
// One item per cycle when the output is not stalled; items pass through the
// input register, the queue and the result register.
// The queue holds up to QUEUE_DEPTH items, so input keeps flowing after the
// output stalls until the queue fills, then in_stall rises.
// Reset leaves the pins released, the sequencer idle and phase_ticks at 720.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer import i2cms_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd_valid,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_tx_ack,
  input  logic        in_sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_rx_byte,
  output logic        out_rx_ack
);

  logic        fwd_valid;
  logic        q_full;
  i2cms_item_t fwd_item;
  logic        q_nonempty;
  logic        q_pop;
  i2cms_item_t q_item;

  i2cms_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd_valid (in_cmd_valid),
    .in_req_type  (in_req_type),
    .in_tx_byte   (in_tx_byte),
    .in_tx_ack    (in_tx_ack),
    .in_sda_in    (in_sda_in),
    .fwd_valid    (fwd_valid),
    .fwd_full     (q_full),
    .fwd_item     (fwd_item)
  );

  i2cms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fwd_valid),
    .push_item (fwd_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .pop_item  (q_item)
  );

  i2cms_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .q_nonempty   (q_nonempty),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_scl_out  (out_scl_out),
    .out_sda_out  (out_sda_out),
    .out_busy_res (out_busy_res),
    .out_done_res (out_done_res),
    .out_rx_byte  (out_rx_byte),
    .out_rx_ack   (out_rx_ack)
  );

endmodule

// ===== sim/i2c_master_bit_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_tb
// Self-checking bench for the I2C master bit sequencer. Every accepted item
// is one sequencer tick; a cycle-accurate model of the pin sequencer predicts
// the pin levels, busy/done flags and received data for that tick, and each
// result item is compared with the oldest prediction. Directed commands cover
// every request, field extremes, ignored requests and zero step length; the
// random part plays well-formed bus transactions mixed with noise over
// several step lengths, with random gaps, stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_tb import i2cms_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SDA_LOW     = 0;
  localparam int SDA_HIGH    = 1;
  localparam int SDA_RANDOM  = 2;

  localparam logic [2:0] REQ_RESERVED_LO = 3'd6;
  localparam logic [2:0] REQ_RESERVED_HI = 3'd7;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       tx_ack;
    logic       sda_in;
  } tick_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       rx_ack;
  } pin_levels_t;

  typedef enum logic [2:0] {
    BUS_IDLE, BUS_ADDR, BUS_ADDR_ACK, BUS_DATA, BUS_WR_ACK, BUS_RD_ACK
  } bus_state_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd_valid;
  logic [2:0]  in_req_type;
  logic [7:0]  in_tx_byte;
  logic        in_tx_ack;
  logic        in_sda_in;
  logic        out_valid;
  logic        out_stall;
  logic        out_scl_out;
  logic        out_sda_out;
  logic        out_busy_res;
  logic        out_done_res;
  logic [7:0]  out_rx_byte;
  logic        out_rx_ack;

  // sequencer model state
  logic [15:0] tick_per_step;
  int          seq_timer;
  int          seq_step;
  logic [2:0]  seq_cmd;
  logic        seq_running;
  logic [7:0]  rx_shift;
  logic        scl_lvl;
  logic        sda_lvl;
  logic        ack_lvl;
  logic [7:0]  tx_hold;

  pin_levels_t expected_pins_q[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          sda_mode = SDA_RANDOM;
  int          hold_req = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_stalls_on = 1'b1;
  bus_state_t  bus_state = BUS_IDLE;

  i2c_master_bit_sequencer i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd_valid (in_cmd_valid),
    .in_req_type  (in_req_type),
    .in_tx_byte   (in_tx_byte),
    .in_tx_ack    (in_tx_ack),
    .in_sda_in    (in_sda_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_scl_out  (out_scl_out),
    .out_sda_out  (out_sda_out),
    .out_busy_res (out_busy_res),
    .out_done_res (out_done_res),
    .out_rx_byte  (out_rx_byte),
    .out_rx_ack   (out_rx_ack)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("i2c_master_bit_sequencer_tb: done, errors");
      $finish;
    end
  end

  function automatic pin_levels_t sequence_tick(tick_item_t it);
    pin_levels_t r;
    int          limit;
    int          n_steps;
    int          k;
    int          b;
    r = '0;
    limit = (tick_per_step == 16'd0) ? 1 : int'(tick_per_step);
    if (!seq_running && it.cmd_valid && it.req_type <= CMD_RACK) begin
      seq_running = 1'b1;
      seq_cmd = it.req_type;
      seq_step = 0;
      seq_timer = 0;
      tx_hold = (it.req_type == CMD_SACK) ? {7'd0, it.tx_ack} : it.tx_byte;
    end
    if (seq_running) begin
      r.busy = 1'b1;
      if (seq_timer == 0) begin
        case (seq_cmd)
          CMD_START: begin
            case (seq_step)
              0: sda_lvl = 1'b1;
              1: scl_lvl = 1'b1;
              2: sda_lvl = 1'b0;
              default: scl_lvl = 1'b0;
            endcase
          end
          CMD_STOP: begin
            case (seq_step)
              0: sda_lvl = 1'b0;
              1: scl_lvl = 1'b1;
              default: sda_lvl = 1'b1;
            endcase
          end
          CMD_WRITE: begin
            k = seq_step % 3;
            b = (seq_step / 3) & 7;
            if (k == 0) sda_lvl = |(tx_hold & (MSB_MASK >> b));
            else if (k == 1) scl_lvl = 1'b1;
            else scl_lvl = 1'b0;
          end
          CMD_READ: begin
            if (seq_step == 0) begin
              sda_lvl = 1'b1;
              rx_shift = 8'd0;
            end else begin
              k = (seq_step - 1) % 3;
              b = ((seq_step - 1) / 3) & 7;
              if (k == 0) scl_lvl = 1'b1;
              else if (k == 1) begin
                if (it.sda_in) rx_shift = rx_shift | (MSB_MASK >> b);
              end else scl_lvl = 1'b0;
            end
          end
          CMD_SACK: begin
            case (seq_step)
              0: sda_lvl = tx_hold[0];
              1: scl_lvl = 1'b1;
              default: scl_lvl = 1'b0;
            endcase
          end
          default: begin
            case (seq_step)
              0: sda_lvl = 1'b1;
              1: scl_lvl = 1'b1;
              2: ack_lvl = it.sda_in;
              default: scl_lvl = 1'b0;
            endcase
          end
        endcase
      end
      seq_timer++;
      if (seq_timer >= limit) begin
        seq_timer = 0;
        seq_step = (seq_step + 1) & 31;
        case (seq_cmd)
          CMD_START: n_steps = 4;
          CMD_STOP:  n_steps = 3;
          CMD_WRITE: n_steps = 24;
          CMD_READ:  n_steps = 25;
          CMD_SACK:  n_steps = 3;
          default:   n_steps = 4;
        endcase
        if (seq_step >= n_steps) begin
          seq_running = 1'b0;
          seq_step = 0;
          r.done = 1'b1;
        end
      end
    end
    r.scl = scl_lvl;
    r.sda = sda_lvl;
    r.rx_byte = rx_shift;
    r.rx_ack = ack_lvl;
    return r;
  endfunction

  function automatic tick_item_t random_tick();
    tick_item_t it;
    it.cmd_valid = 1'($urandom_range(0, 1));
    it.req_type = 3'($urandom_range(0, 7));
    it.tx_byte = 8'($urandom_range(0, 255));
    it.tx_ack = 1'($urandom_range(0, 1));
    if (sda_mode == SDA_RANDOM) it.sda_in = 1'($urandom_range(0, 1));
    else it.sda_in = (sda_mode == SDA_HIGH);
    return it;
  endfunction

  function automatic tick_item_t command_tick(logic [2:0] req, logic [7:0] data, logic ack);
    tick_item_t it;
    it = random_tick();
    it.cmd_valid = 1'b1;
    it.req_type = req;
    it.tx_byte = data;
    it.tx_ack = ack;
    return it;
  endfunction

  task automatic send_tick(tick_item_t it);
    int gap;
    int roll;
    gap = 0;
    if (tx_gaps_on) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) gap = 0;
      else if (roll < 96) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
    end
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_cmd_valid <= it.cmd_valid;
    in_req_type  <= it.req_type;
    in_tx_byte   <= it.tx_byte;
    in_tx_ack    <= it.tx_ack;
    in_sda_in    <= it.sda_in;
    do @(posedge clk); while (in_stall);
    expected_pins_q.push_back(sequence_tick(it));
  endtask

  task automatic run_command(logic [2:0] req, logic [7:0] data, logic ack);
    send_tick(command_tick(req, data, ack));
    while (seq_running) send_tick(random_tick());
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_pins_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_phase(logic [15:0] ticks);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ticks;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    tick_per_step = ticks;
  endtask

  task automatic play_traffic(int n_ticks);
    int         sent;
    int         roll;
    tick_item_t it;
    sent = 0;
    while (sent < n_ticks) begin
      if (sent % 100 == 0) begin
        tx_gaps_on = ($urandom_range(0, 3) != 0);
        rx_stalls_on = ($urandom_range(0, 3) != 0);
      end
      roll = $urandom_range(0, 99);
      if (seq_running || roll < 10) begin
        send_tick(random_tick());
      end else if (roll < 20) begin
        it = random_tick();
        it.cmd_valid = 1'b0;
        send_tick(it);
      end else begin
        it = command_tick(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        case (bus_state)
          BUS_IDLE: bus_state = BUS_ADDR;
          BUS_ADDR: begin
            it.req_type = CMD_WRITE;
            bus_state = BUS_ADDR_ACK;
          end
          BUS_ADDR_ACK, BUS_WR_ACK: begin
            it.req_type = CMD_RACK;
            bus_state = BUS_DATA;
          end
          BUS_RD_ACK: begin
            it.req_type = CMD_SACK;
            bus_state = BUS_DATA;
          end
          default: begin
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
              it.req_type = CMD_STOP;
              bus_state = BUS_IDLE;
            end else if (roll < 30) begin
              bus_state = BUS_ADDR;
            end else if (roll < 65) begin
              it.req_type = CMD_WRITE;
              bus_state = BUS_WR_ACK;
            end else begin
              it.req_type = CMD_READ;
              bus_state = BUS_RD_ACK;
            end
          end
        endcase
        send_tick(it);
      end
      sent++;
    end
    while (seq_running) send_tick(random_tick());
  endtask

  task automatic test_reset_step_length();
    send_tick(command_tick(CMD_START, 8'h00, 1'b0));
    repeat (740) send_tick(random_tick());
    write_phase(16'd1);
    while (seq_running) send_tick(random_tick());
  endtask

  task automatic test_directed_commands();
    tick_item_t it;
    write_phase(16'd1);
    run_command(CMD_START, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'hFF, 1'b1);
    run_command(CMD_WRITE, 8'hA5, 1'b0);
    sda_mode = SDA_LOW;
    run_command(CMD_RACK, 8'hFF, 1'b1);
    run_command(CMD_READ, 8'hFF, 1'b1);
    sda_mode = SDA_HIGH;
    run_command(CMD_RACK, 8'h00, 1'b0);
    run_command(CMD_READ, 8'h00, 1'b0);
    sda_mode = SDA_RANDOM;
    run_command(CMD_READ, 8'h5A, 1'b1);
    run_command(CMD_SACK, 8'hFF, 1'b0);
    run_command(CMD_SACK, 8'h00, 1'b1);
    run_command(CMD_STOP, 8'h00, 1'b0);
    // reserved request codes leave the sequencer idle
    run_command(REQ_RESERVED_LO, 8'hFF, 1'b1);
    run_command(REQ_RESERVED_HI, 8'h00, 1'b0);
    // back-to-back requests while busy are dropped
    send_tick(command_tick(CMD_START, 8'h00, 1'b0));
    repeat (3) send_tick(command_tick(CMD_STOP, 8'hFF, 1'b1));
    while (seq_running) send_tick(random_tick());
    it = random_tick();
    it.cmd_valid = 1'b0;
    repeat (4) send_tick(it);
  endtask

  task automatic test_zero_step_length();
    write_phase(16'd0);
    run_command(CMD_START, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'($urandom_range(0, 255)), 1'b0);
    run_command(CMD_RACK, 8'h00, 1'b0);
    run_command(CMD_READ, 8'h00, 1'b0);
    run_command(CMD_SACK, 8'h00, 1'b1);
    run_command(CMD_STOP, 8'h00, 1'b0);
  endtask

  task automatic test_random_traffic();
    write_phase(16'd1);
    play_traffic(350);
    write_phase(16'd2);
    play_traffic(300);
    write_phase(16'($urandom_range(3, 7)));
    play_traffic(250);
  endtask

  task automatic test_output_holdoff();
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    hold_req = 300;
    play_traffic(200);
    rx_stalls_on = 1'b1;
  endtask

  task automatic test_max_step_length();
    write_phase(16'hFFFF);
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    send_tick(command_tick(CMD_START, 8'h00, 1'b0));
    repeat (100) send_tick(random_tick());
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      int n;
      @(negedge clk);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 9) == 0) begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    pin_levels_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pins_q.size() == 0) begin
        $error("result item with no prediction pending");
        error_count++;
      end else begin
        e = expected_pins_q.pop_front();
        compare_field("scl_out", 8'(e.scl), 8'(out_scl_out));
        compare_field("sda_out", 8'(e.sda), 8'(out_sda_out));
        compare_field("busy_res", 8'(e.busy), 8'(out_busy_res));
        compare_field("done_res", 8'(e.done), 8'(out_done_res));
        compare_field("rx_byte", e.rx_byte, out_rx_byte);
        compare_field("rx_ack", 8'(e.rx_ack), 8'(out_rx_ack));
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 16'd0;
    in_valid     = 1'b0;
    in_cmd_valid = 1'b0;
    in_req_type  = CMD_START;
    in_tx_byte   = 8'd0;
    in_tx_ack    = 1'b0;
    in_sda_in    = 1'b1;
    tick_per_step = PHASE_RESET;
    seq_timer    = 0;
    seq_step     = 0;
    seq_cmd      = CMD_START;
    seq_running  = 1'b0;
    rx_shift     = 8'd0;
    scl_lvl      = 1'b1;
    sda_lvl      = 1'b1;
    ack_lvl      = 1'b0;
    tx_hold      = 8'd0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_step_length();
    test_directed_commands();
    test_zero_step_length();
    test_random_traffic();
    test_output_holdoff();
    test_max_step_length();

    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("i2c_master_bit_sequencer_tb: done, clean");
    end else begin
      $display("i2c_master_bit_sequencer_tb: done, errors");
    end
    $finish;
  end

endmodule
